FILE: sv/kfq_pkg.sv
// Shared types and codes for the keyed flight queue.
`default_nettype none
package kfq_pkg;

	localparam logic [1:0] KIND_ENQ    = 2'd0;
	localparam logic [1:0] KIND_QUERY  = 2'd1;
	localparam logic [1:0] KIND_NOTICE = 2'd2;
	localparam logic [1:0] KIND_END    = 2'd3;

	localparam logic [1:0] FS_OK      = 2'd0;
	localparam logic [1:0] FS_STALLED = 2'd1;
	localparam logic [1:0] FS_FATAL   = 2'd2;

	typedef struct packed {
		logic [1:0]  kind;
		logic [1:0]  status;
		logic [15:0] payload;
		logic [7:0]  key;
		logic [2:0]  code;
		logic        finalize;
		logic        last;
	} kfq_res_t;

endpackage
`default_nettype wire

FILE: sv/kfq_out_reg.sv
// Output register that holds one result beat until the receiver takes it.
`default_nettype none
module kfq_out_reg (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             load,
	input  wire kfq_pkg::kfq_res_t din,
	input  wire logic             stall,
	output logic                  valid,
	output kfq_pkg::kfq_res_t     dout,
	output logic                  free
);
	import kfq_pkg::*;

	logic     valid_q;
	kfq_res_t data_q;

	assign free  = !valid_q || !stall;
	assign valid = valid_q;
	assign dout  = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			data_q <= din;
		end
	end

endmodule
`default_nettype wire

FILE: sv/keyed_flight_queue_with_staging.sv
// Keyed flight queue: ring of pending work, per-key staging slots, flush walker.
//
// Input channel (in_valid/in_stall) takes one beat per request: enqueue,
// flush start, or the answer to the entry query that is pending. Output
// channel (out_valid/out_stall) returns result beats; last marks the final
// beat caused by one input beat. An enqueue's status beat is formed in the
// execute state and registered in the output register. A flush walks the
// staging marks and then the ring marks one entry per cycle, and at each
// marked entry reads the entry from memory and issues a query; empty slots
// and ring entries are skipped. A completion notice is emitted from the
// answer state as the walk moves on, and waits there only while the output
// register is still full.
// The input is stalled while a request is being worked on; results sit in
// an output register, and when the receiver stalls the walk waits at the
// next result. Reset clears ring and staging marks, the counters and the
// configuration (notices and finalize on, all staging slots in use); no
// clearing pass is needed. Configuration writes apply at once.
`default_nettype none
module keyed_flight_queue_with_staging #(
	parameter int RING_DEPTH    = 16,
	parameter int STAGING_SLOTS = 256,
	parameter int WORD_BITS     = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [8:0]  cfg_data,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [1:0]  action,
	input  wire logic [7:0]  entry_key,
	input  wire logic [15:0] payload_handle,
	input  wire logic        ready_req,
	input  wire logic [2:0]  consume_code,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [1:0]       kind,
	output logic [1:0]       status,
	output logic [15:0]      out_payload,
	output logic [7:0]       out_key,
	output logic [2:0]       completion_code,
	output logic             finalize,
	output logic             last
);
	import kfq_pkg::*;

	localparam int RI_W   = $clog2(RING_DEPTH);
	localparam int CNT_W  = $clog2(2 * RING_DEPTH);
	localparam int SLOT_W = $clog2(STAGING_SLOTS);
	localparam int SCAN_W = (SLOT_W + 1 > CNT_W) ? SLOT_W + 1 : CNT_W;
	localparam int CMP_W  = (SCAN_W > 9) ? SCAN_W : 9;
	localparam int WORDS  = STAGING_SLOTS / WORD_BITS;

	localparam logic [2:0] S_IN   = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_ADV  = 3'd2;
	localparam logic [2:0] S_QRD  = 3'd3;
	localparam logic [2:0] S_ANS  = 3'd4;
	localparam logic [2:0] S_END  = 3'd5;

	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_A    = 2'd1;
	localparam logic [1:0] PH_B    = 2'd2;
	localparam logic [1:0] PH_RING = 2'd3;

	localparam logic [1:0] ACT_ENQ   = 2'd0;
	localparam logic [1:0] ACT_FLUSH = 2'd1;
	localparam logic [1:0] ACT_ANS   = 2'd2;

	localparam logic [2:0] CC_OK  = 3'd0;
	localparam logic [2:0] CC_REL = 3'd1;
	localparam logic [2:0] CC_ABT = 3'd2;
	localparam logic [2:0] CC_STL = 3'd3;
	localparam logic [2:0] CC_FAT = 3'd4;

	localparam logic [1:0] REG_COMP = 2'd0;
	localparam logic [1:0] REG_FIN  = 2'd1;
	localparam logic [1:0] REG_SIZE = 2'd2;

	function automatic logic [RI_W-1:0] ring_idx(input logic [CNT_W-1:0] c);
		logic [CNT_W:0] w;
		w = {1'b0, c};
		if (w >= (CNT_W+1)'(RING_DEPTH)) begin
			w = w - (CNT_W+1)'(RING_DEPTH);
		end
		return RI_W'(w);
	endfunction

	function automatic logic [CNT_W-1:0] cnt_inc(input logic [CNT_W-1:0] c);
		logic [CNT_W:0] w;
		w = {1'b0, c} + (CNT_W+1)'(1);
		if (w >= (CNT_W+1)'(2 * RING_DEPTH)) begin
			w = '0;
		end
		return CNT_W'(w);
	endfunction

	function automatic logic [SLOT_W-1:0] key_slot(input logic [7:0] k);
		logic [12:0] t;
		t = 13'(k);
		for (int i = 0; i < 4; i++) begin
			if (t >= 13'(STAGING_SLOTS)) begin
				t = t - 13'(STAGING_SLOTS);
			end
		end
		return SLOT_W'(t);
	endfunction

	// Configuration registers.
	logic       comp_en_q, fin_en_q;
	logic [8:0] stg_size_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			comp_en_q  <= 1'b1;
			fin_en_q   <= 1'b1;
			stg_size_q <= 9'd256;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_COMP: comp_en_q  <= cfg_data[0];
				REG_FIN:  fin_en_q   <= cfg_data[0];
				REG_SIZE: stg_size_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Control state.
	logic [2:0]               state_q, state_d;
	logic [1:0]               phase_q, phase_d;
	logic [SCAN_W-1:0]        scan_q, scan_d;
	logic [CNT_W-1:0]         head_q, head_d, tail_q, tail_d;
	logic [7:0]               cursor_q, cursor_d, origin_q, origin_d;
	logic                     cws_q, cws_d;
	logic [1:0]               end_st_q, end_st_d;
	logic [RING_DEPTH-1:0]    ring_mark_q;
	logic [STAGING_SLOTS-1:0] stg_mark_q;

	// Latched request and current entry.
	logic [1:0]  act_q;
	logic [7:0]  key_in_q;
	logic [15:0] pay_in_q;
	logic        rdy_q;
	logic [2:0]  code_q;
	logic [15:0] cur_pay_q, cur_pay_d;
	logic [7:0]  cur_key_q, cur_key_d;

	// Memories.
	logic [7:0]  ring_key_mem [RING_DEPTH];
	logic [15:0] ring_pay_mem [RING_DEPTH];
	logic [15:0] stg_pay_mem  [STAGING_SLOTS];
	logic [7:0]  ring_key_rd;
	logic [15:0] ring_pay_rd, stg_pay_rd;

	logic              ring_we, ring_re, stg_we, stg_re;
	logic [RI_W-1:0]   ring_waddr, ring_raddr;
	logic [SLOT_W-1:0] stg_waddr, stg_raddr;
	logic              rm_set, rm_clr, sm_set, sm_clr;
	logic [RI_W-1:0]   rm_idx;
	logic [SLOT_W-1:0] sm_idx;

	logic     emit_v, out_free;
	kfq_res_t emit_d, out_d;

	logic [CNT_W-1:0]  scan_cnt, used;
	logic [RI_W-1:0]   p_ri;
	logic [SLOT_W-1:0] p_slot, k_slot;
	logic [CMP_W-1:0]  lim, bound;
	logic              sweep, first, ntc_need;

	assign scan_cnt = scan_q[CNT_W-1:0];
	assign p_ri     = ring_idx(scan_cnt);
	assign p_slot   = scan_q[SLOT_W-1:0];
	assign k_slot   = key_slot(cur_key_q);
	assign sweep    = (phase_q == PH_A) || (phase_q == PH_B);
	assign first    = (phase_q == PH_A);
	assign in_stall = (state_q != S_IN);

	always_comb begin
		logic [CNT_W:0] diff;
		diff = {1'b0, tail_q} - {1'b0, head_q};
		if (tail_q < head_q) begin
			diff = diff + (CNT_W+1)'(2 * RING_DEPTH);
		end
		used = CNT_W'(diff);
	end

	// Swept slot range: size rounded up to whole words, capped at the slot count.
	// The smallest word multiple that covers the size is picked by comparing
	// against each multiple in turn.
	always_comb begin
		int sz;
		int lim_i;
		sz = int'(stg_size_q);
		if (sz == 0) begin
			sz = 1;
		end
		if (sz > STAGING_SLOTS) begin
			sz = STAGING_SLOTS;
		end
		lim_i = STAGING_SLOTS;
		for (int k = WORDS; k >= 1; k--) begin
			if (k * WORD_BITS >= sz) begin
				lim_i = k * WORD_BITS;
			end
		end
		lim   = CMP_W'(lim_i);
		bound = lim;
		if (phase_q == PH_B && CMP_W'(origin_q) < lim) begin
			bound = CMP_W'(origin_q);
		end
	end

	always_comb begin
		if (sweep) begin
			ntc_need = rdy_q && ((code_q == CC_REL) || (code_q == CC_ABT) ||
				(code_q == CC_STL) || (code_q == CC_FAT) || (code_q == CC_OK && !first));
		end else begin
			ntc_need = rdy_q && (code_q <= CC_FAT);
		end
	end

	always_comb begin
		state_d   = state_q;
		phase_d   = phase_q;
		scan_d    = scan_q;
		head_d    = head_q;
		tail_d    = tail_q;
		cursor_d  = cursor_q;
		origin_d  = origin_q;
		cws_d     = cws_q;
		end_st_d  = end_st_q;
		cur_pay_d = cur_pay_q;
		cur_key_d = cur_key_q;
		ring_we   = 1'b0;
		ring_re   = 1'b0;
		stg_we    = 1'b0;
		stg_re    = 1'b0;
		ring_waddr = ring_idx(tail_q);
		ring_raddr = p_ri;
		stg_waddr = k_slot;
		stg_raddr = p_slot;
		rm_set    = 1'b0;
		rm_clr    = 1'b0;
		rm_idx    = p_ri;
		sm_set    = 1'b0;
		sm_clr    = 1'b0;
		sm_idx    = p_slot;
		emit_v    = 1'b0;
		emit_d    = '0;
		case (state_q)
			S_IN: begin
				if (in_valid) begin
					state_d = S_EXEC;
				end
			end
			S_EXEC: begin
				case (act_q)
					ACT_ENQ: begin
						if (out_free) begin
							emit_v      = 1'b1;
							emit_d.kind = KIND_ENQ;
							emit_d.last = 1'b1;
							if (used >= CNT_W'(RING_DEPTH)) begin
								emit_d.status = FS_STALLED;
							end else begin
								ring_we = 1'b1;
								rm_set  = 1'b1;
								rm_idx  = ring_idx(tail_q);
								tail_d  = cnt_inc(tail_q);
							end
							state_d = S_IN;
						end
					end
					ACT_FLUSH: begin
						if (phase_q != PH_IDLE) begin
							state_d = S_IN;
						end else if (head_q == tail_q) begin
							if (out_free) begin
								emit_v      = 1'b1;
								emit_d.kind = KIND_END;
								emit_d.last = 1'b1;
								state_d     = S_IN;
							end
						end else begin
							phase_d  = PH_A;
							scan_d   = SCAN_W'(cursor_q);
							origin_d = cursor_q;
							cws_d    = 1'b0;
							state_d  = S_ADV;
						end
					end
					ACT_ANS: begin
						state_d = (phase_q != PH_IDLE) ? S_ANS : S_IN;
					end
					default: state_d = S_IN;
				endcase
			end
			S_ADV: begin
				if (sweep) begin
					if (CMP_W'(scan_q) < bound) begin
						if (stg_mark_q[p_slot]) begin
							stg_re  = 1'b1;
							state_d = S_QRD;
						end else begin
							scan_d = scan_q + SCAN_W'(1);
						end
					end else if (first) begin
						phase_d = PH_B;
						scan_d  = '0;
					end else begin
						if (!cws_q) begin
							cursor_d = '0;
						end
						phase_d = PH_RING;
						scan_d  = SCAN_W'(head_q);
					end
				end else begin
					if (scan_cnt != tail_q) begin
						if (ring_mark_q[p_ri]) begin
							ring_re = 1'b1;
							state_d = S_QRD;
						end else begin
							scan_d = SCAN_W'(cnt_inc(scan_cnt));
						end
					end else if (out_free) begin
						emit_v          = 1'b1;
						emit_d.kind     = KIND_END;
						emit_d.finalize = (scan_cnt != head_q) && fin_en_q;
						emit_d.last     = 1'b1;
						head_d          = scan_cnt;
						phase_d         = PH_IDLE;
						state_d         = S_IN;
					end
				end
			end
			S_QRD: begin
				if (out_free) begin
					cur_pay_d      = sweep ? stg_pay_rd : ring_pay_rd;
					cur_key_d      = sweep ? 8'(scan_q) : ring_key_rd;
					emit_v         = 1'b1;
					emit_d.kind    = KIND_QUERY;
					emit_d.payload = cur_pay_d;
					emit_d.key     = cur_key_d;
					emit_d.last    = 1'b1;
					state_d        = S_IN;
				end
			end
			S_ANS: begin
				if (!(ntc_need && comp_en_q && !out_free)) begin
					logic endf;
					logic stage_try;
					endf      = 1'b0;
					stage_try = 1'b0;
					if (sweep) begin
						if (!rdy_q) begin
							if (!cws_q) begin
								cws_d    = 1'b1;
								cursor_d = 8'(scan_q);
							end
						end else if (code_q == CC_REL || code_q == CC_ABT ||
							(code_q == CC_FAT && first)) begin
							sm_clr = 1'b1;
						end else if (code_q == CC_STL) begin
							endf     = 1'b1;
							end_st_d = FS_STALLED;
						end else if (code_q == CC_FAT) begin
							endf     = 1'b1;
							end_st_d = FS_FATAL;
						end
					end else begin
						if (!rdy_q) begin
							stage_try = 1'b1;
						end else if (code_q == CC_REL || code_q == CC_ABT) begin
							rm_clr = 1'b1;
						end else if (code_q == CC_STL || code_q == CC_FAT) begin
							endf     = 1'b1;
							end_st_d = (code_q == CC_STL) ? FS_STALLED : FS_FATAL;
						end else if (code_q == CC_OK) begin
							stage_try = 1'b1;
						end
						if (stage_try) begin
							// A taken slot blocks this entry: it becomes the new head.
							if (stg_mark_q[k_slot]) begin
								head_d   = scan_cnt;
								endf     = 1'b1;
								end_st_d = FS_STALLED;
							end else begin
								stg_we = 1'b1;
								sm_set = 1'b1;
								sm_idx = k_slot;
								rm_clr = 1'b1;
							end
						end
					end
					if (ntc_need && comp_en_q) begin
						emit_v         = 1'b1;
						emit_d.kind    = KIND_NOTICE;
						emit_d.payload = cur_pay_q;
						emit_d.key     = cur_key_q;
						emit_d.code    = code_q;
					end
					if (endf) begin
						state_d = S_END;
					end else begin
						scan_d  = sweep ? scan_q + SCAN_W'(1) : SCAN_W'(cnt_inc(scan_cnt));
						state_d = S_ADV;
					end
				end
			end
			S_END: begin
				if (out_free) begin
					emit_v        = 1'b1;
					emit_d.kind   = KIND_END;
					emit_d.status = end_st_q;
					emit_d.last   = 1'b1;
					phase_d       = PH_IDLE;
					state_d       = S_IN;
				end
			end
			default: state_d = S_IN;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IN;
			phase_q     <= PH_IDLE;
			scan_q      <= '0;
			head_q      <= '0;
			tail_q      <= '0;
			cursor_q    <= '0;
			origin_q    <= '0;
			cws_q       <= 1'b0;
			end_st_q    <= FS_OK;
			ring_mark_q <= '0;
			stg_mark_q  <= '0;
		end else begin
			state_q  <= state_d;
			phase_q  <= phase_d;
			scan_q   <= scan_d;
			head_q   <= head_d;
			tail_q   <= tail_d;
			cursor_q <= cursor_d;
			origin_q <= origin_d;
			cws_q    <= cws_d;
			end_st_q <= end_st_d;
			if (rm_set) begin
				ring_mark_q[rm_idx] <= 1'b1;
			end else if (rm_clr) begin
				ring_mark_q[rm_idx] <= 1'b0;
			end
			if (sm_set) begin
				stg_mark_q[sm_idx] <= 1'b1;
			end else if (sm_clr) begin
				stg_mark_q[sm_idx] <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			act_q    <= action;
			key_in_q <= entry_key;
			pay_in_q <= payload_handle;
			rdy_q    <= ready_req;
			code_q   <= consume_code;
		end
		cur_pay_q <= cur_pay_d;
		cur_key_q <= cur_key_d;
	end

	always_ff @(posedge clk) begin
		if (ring_we) begin
			ring_key_mem[ring_waddr] <= key_in_q;
			ring_pay_mem[ring_waddr] <= pay_in_q;
		end
		if (ring_re) begin
			ring_key_rd <= ring_key_mem[ring_raddr];
			ring_pay_rd <= ring_pay_mem[ring_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (stg_we) begin
			stg_pay_mem[stg_waddr] <= cur_pay_q;
		end
		if (stg_re) begin
			stg_pay_rd <= stg_pay_mem[stg_raddr];
		end
	end

	kfq_out_reg u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.load   (emit_v),
		.din    (emit_d),
		.stall  (out_stall),
		.valid  (out_valid),
		.dout   (out_d),
		.free   (out_free)
	);

	assign kind            = out_d.kind;
	assign status          = out_d.status;
	assign out_payload     = out_d.payload;
	assign out_key         = out_d.key;
	assign completion_code = out_d.code;
	assign finalize        = out_d.finalize;
	assign last            = out_d.last;

	a_ring_bound: assert property (@(posedge clk) disable iff (!arst_n)
		used <= CNT_W'(RING_DEPTH))
		else $error("ring occupancy above depth");

	a_ring_query_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IN && phase_q == PH_RING) |-> ring_mark_q[p_ri])
		else $error("pending ring query on an unmarked entry");

	a_stg_query_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IN && (phase_q == PH_A || phase_q == PH_B)) |-> stg_mark_q[p_slot])
		else $error("pending staging query on an empty slot");

endmodule
`default_nettype wire
